FILE: rtl/core/tids_pkg.sv
package tids_pkg;

  // Telnet protocol bytes.
  localparam logic [7:0] B_IAC  = 8'hff;
  localparam logic [7:0] B_DONT = 8'hfe;
  localparam logic [7:0] B_DO   = 8'hfd;
  localparam logic [7:0] B_WONT = 8'hfc;
  localparam logic [7:0] B_WILL = 8'hfb;
  localparam logic [7:0] B_SB   = 8'hfa;
  localparam logic [7:0] B_SE   = 8'hf0;

  // Option codes.
  localparam logic [7:0] OPT_ECHO = 8'h01;
  localparam logic [7:0] OPT_SGA  = 8'h03;
  localparam logic [7:0] OPT_NAWS = 8'h1f;
  localparam logic [7:0] OPT_EO   = 8'h24;

  // Window size after reset.
  localparam logic [15:0] WIDTH_RESET  = 16'd80;
  localparam logic [15:0] HEIGHT_RESET = 16'd24;

  // Result kinds, also used as action codes in the queue.
  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_REPLY  = 2'd1,
    KIND_STATUS = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_e;

  // Index of the last byte in the reply to WILL EO.
  localparam logic [1:0] REPLY_LAST = 2'd2;

  // One action handed from the parser to the result generator.
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;
    logic [15:0] width;
    logic [15:0] height;
    logic        echo_acked;
    logic        sga_acked;
  } action_t;

  // Reply bytes IAC DONT EO.
  function automatic logic [7:0] eo_reply_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = B_IAC;
      2'd1:    b = B_DONT;
      default: b = OPT_EO;
    endcase
    return b;
  endfunction

endpackage

FILE: rtl/core/tids_if.sv
// Input channel: one received byte with its side flags.
interface tids_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       end_of_chunk;
  logic       note_echo_offered;
  logic       note_sga_offered;

  modport source (output valid, rx_byte, end_of_chunk, note_echo_offered,
                  note_sga_offered, input ready);
  modport sink   (input valid, rx_byte, end_of_chunk, note_echo_offered,
                  note_sga_offered, output ready);
endinterface

// Output channel: one result item.
interface tids_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  out_byte;
  logic        last_of_run;
  logic [15:0] window_width;
  logic [15:0] window_height;
  logic        echo_acked;
  logic        sga_acked;

  modport source (output valid, kind, out_byte, last_of_run, window_width,
                  window_height, echo_acked, sga_acked, input ready);
  modport sink   (input valid, kind, out_byte, last_of_run, window_width,
                  window_height, echo_acked, sga_acked, output ready);
endinterface

FILE: rtl/core/tids_front.sv
module tids_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  tids_in_if.sink          rx,
  input  logic             full_i,
  output logic             push_o,
  output tids_pkg::action_t push_data_o
);
  import tids_pkg::*;

  // Parser phase codes.
  localparam logic [2:0] PH_DATA    = 3'd0;
  localparam logic [2:0] PH_CMD     = 3'd1;
  localparam logic [2:0] PH_OPT     = 3'd2;
  localparam logic [2:0] PH_SBOPT   = 3'd3;
  localparam logic [2:0] PH_SBVAL   = 3'd4;
  localparam logic [2:0] PH_DISCARD = 3'd5;

  logic [2:0]  phase_q, phase_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [2:0]  sub_q, sub_d;
  logic [23:0] size_q, size_d;
  logic        echo_q, echo_d;
  logic        sga_q, sga_d;
  logic [15:0] width_q, width_d;
  logic [15:0] height_q, height_d;
  logic        accept;
  logic        act_valid;
  action_t     act;
  logic        echo_eff;
  logic        sga_eff;
  logic [31:0] size_new;
  logic [2:0]  sub_inc;
  logic [7:0]  b;

  // A byte is taken whenever the queue has room for its action.
  assign rx.ready = !full_i;
  assign accept   = rx.valid && rx.ready;
  assign b        = rx.rx_byte;

  // Offer flags are set before the byte is parsed.
  assign echo_eff = echo_q | rx.note_echo_offered;
  assign sga_eff  = sga_q | rx.note_sga_offered;
  assign size_new = {size_q, b};
  assign sub_inc  = sub_q + 3'd1;

  // Classify the byte against the current phase.
  always_comb begin
    phase_d   = phase_q;
    cmd_d     = cmd_q;
    sub_d     = sub_q;
    size_d    = size_q;
    echo_d    = echo_eff;
    sga_d     = sga_eff;
    width_d   = width_q;
    height_d  = height_q;
    act_valid = 1'b0;
    act       = '0;
    case (phase_q)
      PH_CMD: begin
        if (b == B_IAC) begin
          act_valid = 1'b1;
          act.kind  = KIND_DATA;
          act.data  = B_IAC;
          phase_d   = PH_DATA;
        end else if (b == B_WILL || b == B_WONT || b == B_DO || b == B_DONT) begin
          cmd_d   = b;
          phase_d = PH_OPT;
        end else if (b == B_SB) begin
          phase_d = PH_SBOPT;
        end else begin
          act_valid = 1'b1;
          act.kind  = KIND_ERROR;
          act.data  = b;
          phase_d   = PH_DISCARD;
        end
      end
      PH_OPT: begin
        phase_d = PH_DATA;
        if (cmd_q == B_WILL && b == OPT_EO) begin
          act_valid = 1'b1;
          act.kind  = KIND_REPLY;
        end else if (cmd_q == B_DO && b == OPT_ECHO && echo_eff) begin
          echo_d         = 1'b0;
          act_valid      = 1'b1;
          act.kind       = KIND_STATUS;
          act.width      = width_q;
          act.height     = height_q;
          act.echo_acked = 1'b1;
        end else if (cmd_q == B_DO && b == OPT_SGA && sga_eff) begin
          sga_d         = 1'b0;
          act_valid     = 1'b1;
          act.kind      = KIND_STATUS;
          act.width     = width_q;
          act.height    = height_q;
          act.sga_acked = 1'b1;
        end
      end
      PH_SBOPT: begin
        if (b == OPT_NAWS) begin
          sub_d   = 3'd0;
          phase_d = PH_SBVAL;
        end else begin
          act_valid = 1'b1;
          act.kind  = KIND_ERROR;
          act.data  = b;
          phase_d   = PH_DISCARD;
        end
      end
      PH_SBVAL: begin
        // Four size bytes, then two trailing bytes taken unchecked.
        if (sub_q < 3'd4) begin
          size_d = size_new[23:0];
        end
        if (sub_q == 3'd3) begin
          width_d    = size_new[31:16];
          height_d   = size_new[15:0];
          act_valid  = 1'b1;
          act.kind   = KIND_STATUS;
          act.width  = size_new[31:16];
          act.height = size_new[15:0];
        end
        sub_d = sub_inc;
        if (sub_inc >= 3'd6 || sub_inc == 3'd0) begin
          sub_d   = 3'd0;
          phase_d = PH_DATA;
        end
      end
      PH_DISCARD: begin
      end
      default: begin
        // Data phase, and unused codes behave the same way.
        if (b == B_IAC) begin
          phase_d = PH_CMD;
        end else begin
          act_valid = 1'b1;
          act.kind  = KIND_DATA;
          act.data  = b;
          phase_d   = PH_DATA;
        end
      end
    endcase
    // The end of a chunk leaves discard mode.
    if (rx.end_of_chunk && phase_d == PH_DISCARD) begin
      phase_d = PH_DATA;
    end
  end

  assign push_o      = accept && act_valid;
  assign push_data_o = act;

  // Parser state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_DATA;
      cmd_q    <= '0;
      sub_q    <= '0;
      size_q   <= '0;
      echo_q   <= 1'b0;
      sga_q    <= 1'b0;
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (accept) begin
      phase_q  <= phase_d;
      cmd_q    <= cmd_d;
      sub_q    <= sub_d;
      size_q   <= size_d;
      echo_q   <= echo_d;
      sga_q    <= sga_d;
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

endmodule

FILE: rtl/core/tids_queue.sv
module tids_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  tids_pkg::action_t push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              head_valid_o,
  output tids_pkg::action_t head_data_o
);
  import tids_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  action_t       mem_q [DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic          do_push;
  logic          do_pop;

  assign full_o       = (cnt_q == FULL_CNT);
  assign head_valid_o = (cnt_q != '0);
  assign head_data_o  = mem_q[rd_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LAST_PTR) ? '0 : wr_q + PW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == LAST_PTR) ? '0 : rd_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule

FILE: rtl/core/tids_back.sv
module tids_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  tids_pkg::action_t head_data_i,
  output logic              pop_o,
  tids_out_if.source        tx
);
  import tids_pkg::*;

  logic        valid_q;
  logic [1:0]  kind_q;
  logic [7:0]  byte_q;
  logic        last_q;
  logic [15:0] width_q;
  logic [15:0] height_q;
  logic        echo_q;
  logic        sga_q;
  logic [1:0]  step_q;
  logic        load;
  logic        is_reply;
  logic        res_last;
  logic [7:0]  res_byte;

  // The output register refills when empty or being taken.
  assign load     = head_valid_i && (!valid_q || tx.ready);
  assign is_reply = (head_data_i.kind == KIND_REPLY);
  assign res_last = !is_reply || (step_q == REPLY_LAST);
  assign res_byte = is_reply ? eo_reply_byte(step_q) : head_data_i.data;
  assign pop_o    = load && res_last;

  // Valid flag and reply byte counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      step_q  <= '0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        step_q  <= res_last ? 2'd0 : step_q + 2'd1;
      end else if (tx.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q   <= head_data_i.kind;
      byte_q   <= res_byte;
      last_q   <= res_last;
      width_q  <= head_data_i.width;
      height_q <= head_data_i.height;
      echo_q   <= head_data_i.echo_acked;
      sga_q    <= head_data_i.sga_acked;
    end
  end

  assign tx.valid         = valid_q;
  assign tx.kind          = kind_q;
  assign tx.out_byte      = byte_q;
  assign tx.last_of_run   = last_q;
  assign tx.window_width  = width_q;
  assign tx.window_height = height_q;
  assign tx.echo_acked    = echo_q;
  assign tx.sga_acked     = sga_q;

endmodule

FILE: rtl/core/telnet_iac_stream_deframer_core.sv
// Each action is written into the queue, then loaded from it into the output register.
// Throughput: one byte per cycle; the parser takes a byte whenever the action queue has room.
// A WILL EO reply holds the result generator for its three bytes; the queue absorbs it.
// Reset (rst_ni low, asynchronous) empties the queue and output register and returns
// the parser to the data phase with offers cleared and a window size of 80 by 24.
module telnet_iac_stream_deframer_core #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tids_in_if.sink    rx_i,
  tids_out_if.source tx_o
);
  import tids_pkg::*;

  logic    push;
  action_t push_data;
  logic    full;
  logic    pop;
  logic    head_valid;
  action_t head_data;

  // Parser: takes bytes and turns them into actions.
  tids_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx          (rx_i),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // Queue between parser and result generator.
  tids_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_data),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_data_o  (head_data)
  );

  // Result generator: expands actions into result items.
  tids_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_data_i  (head_data),
    .pop_o        (pop),
    .tx           (tx_o)
  );

endmodule
